### hdl/pngcp_pkg.sv
// package for the png chunk stream parser: payload structs, parse phases,
// record kinds and file-format constants; depends on nothing
package pngcp_pkg;

    // input transfer payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } in_item_t;

    // result transfer payload
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [31:0] chunk_type;
        logic [31:0] chunk_length;
        logic [31:0] data_start;
        logic [31:0] stored_crc;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [7:0]  pixel_depth;
        logic [7:0]  color_mode;
        logic [23:0] method_bytes;
        logic        last_of_run;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_HALT = 3'd5
    } phase_t;

    localparam logic [2:0] KIND_CHUNK    = 3'd0;
    localparam logic [2:0] KIND_HEADER   = 3'd1;
    localparam logic [2:0] KIND_BAD_SIG  = 3'd2;
    localparam logic [2:0] KIND_OVERRUN  = 3'd3;
    localparam logic [2:0] KIND_BAD_TYPE = 3'd4;

    localparam logic [7:0] SIG_BYTES [8] = '{
        8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
    };
    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;

    localparam logic [7:0] UPPER_LO = 8'h41;
    localparam logic [7:0] UPPER_HI = 8'h5A;
    localparam logic [7:0] LOWER_LO = 8'h61;
    localparam logic [7:0] LOWER_HI = 8'h7A;

    // header bytes sit at fixed file offsets
    localparam logic [31:0] HDR_WIDTH_FIRST  = 32'd16;
    localparam logic [31:0] HDR_WIDTH_LAST   = 32'd19;
    localparam logic [31:0] HDR_HEIGHT_FIRST = 32'd20;
    localparam logic [31:0] HDR_HEIGHT_LAST  = 32'd23;
    localparam logic [31:0] HDR_SMALL_FIRST  = 32'd24;
    localparam logic [31:0] HDR_SMALL_LAST   = 32'd28;
    localparam logic [31:0] SIG_LAST_POS     = 32'd7;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

endpackage

### hdl/png_chunk_stream_parser_top.sv
// png chunk stream parser, top level: byte-wise chunk walker and result queue
// depends on pngcp_pkg

// The parser takes one file byte per transfer and accepts a byte in every
// cycle while the result queue has room for two records; a byte is fully
// handled in the cycle it is accepted (counters and shift accumulators only),
// so the sustained rate is one byte per clock, and any record it yields shows
// on m_valid from the next cycle. Records go into a four-entry
// queue that drains one record per cycle while m_ready is high; a byte can push
// two records (a chunk record followed by the IHDR header record), so s_ready
// drops only while the queue holds more than two records. After the 8-byte
// signature each chunk yields one chunk record once its stored CRC word is in;
// the CRC is not checked. A bad signature, a chunk length that overruns
// file_size or a non-letter type byte yields one error record and the parser
// ignores bytes until end_of_file. The byte flagged end_of_file returns the
// parser to its signature phase. Write file_size only while no transfer is in
// progress.
module png_chunk_stream_parser_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pngcp_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pngcp_pkg::out_item_t  m_data
);
    import pngcp_pkg::*;

    // configuration
    logic [31:0] file_size_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [1:0]  fcnt_reg, fcnt_next;
    logic        sig_ok_reg, sig_ok_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] offset_reg, offset_next;
    logic        first_seen_reg, first_seen_next;
    logic        first_ihdr_reg, first_ihdr_next;
    logic [31:0] hdr_width_reg, hdr_width_next;
    logic [31:0] hdr_height_reg, hdr_height_next;
    logic [39:0] hdr_small_reg, hdr_small_next;

    // records produced by the byte in this cycle
    out_item_t   rec0, rec1;
    logic [1:0]  rec_cnt;

    // result queue
    out_item_t           rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [RQ_CNT_W-1:0] rq_cnt_reg;

    logic        s_xfer, m_xfer;
    logic [7:0]  b;
    logic        eof;

    assign s_ready = (rq_cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign s_xfer  = s_valid && s_ready;
    assign m_valid = (rq_cnt_reg != '0);
    assign m_xfer  = m_valid && m_ready;
    assign m_data  = rq_mem[rq_rd_ptr_reg];
    assign b       = s_data.data_byte;
    assign eof     = s_data.end_of_file;

    always_comb begin
        logic [32:0] after;
        logic [33:0] end_sum;
        logic [31:0] len_shift;
        logic [31:0] type_shift;
        logic [31:0] remain_dec;
        logic        letter;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        fcnt_next       = fcnt_reg;
        sig_ok_next     = sig_ok_reg;
        len_next        = len_reg;
        type_next       = type_reg;
        crc_next        = crc_reg;
        remain_next     = remain_reg;
        offset_next     = offset_reg;
        first_seen_next = first_seen_reg;
        first_ihdr_next = first_ihdr_reg;
        hdr_width_next  = hdr_width_reg;
        hdr_height_next = hdr_height_reg;
        hdr_small_next  = hdr_small_reg;
        rec0            = '0;
        rec1            = '0;
        rec_cnt         = 2'd0;

        after      = {1'b0, pos_reg} + 33'd1;
        len_shift  = {len_reg[23:0], b};
        type_shift = {type_reg[23:0], b};
        remain_dec = remain_reg - 32'd1;
        end_sum    = {1'b0, after} + {2'b00, len_shift} + 34'd8;
        letter     = (b >= UPPER_LO && b <= UPPER_HI) || (b >= LOWER_LO && b <= LOWER_HI);

        if (s_xfer) begin
            // header bytes are captured by file offset, whatever the phase
            if (pos_reg >= HDR_WIDTH_FIRST && pos_reg <= HDR_WIDTH_LAST) begin
                hdr_width_next = {hdr_width_reg[23:0], b};
            end else if (pos_reg >= HDR_HEIGHT_FIRST && pos_reg <= HDR_HEIGHT_LAST) begin
                hdr_height_next = {hdr_height_reg[23:0], b};
            end else if (pos_reg >= HDR_SMALL_FIRST && pos_reg <= HDR_SMALL_LAST) begin
                hdr_small_next = {hdr_small_reg[31:0], b};
            end

            case (phase_reg)
                PH_SIG: begin
                    sig_ok_next = sig_ok_reg && (b == SIG_BYTES[pos_reg[2:0]]);
                    if (pos_reg >= SIG_LAST_POS) begin
                        if (sig_ok_next) begin
                            phase_next = PH_LEN;
                            fcnt_next  = 2'd0;
                            len_next   = '0;
                        end else begin
                            rec0.record_kind = KIND_BAD_SIG;
                            rec_cnt          = 2'd1;
                            phase_next       = PH_HALT;
                        end
                    end else if (eof) begin
                        // file ended inside the signature
                        rec0.record_kind = KIND_BAD_SIG;
                        rec_cnt          = 2'd1;
                    end
                end
                PH_LEN: begin
                    len_next = len_shift;
                    if (fcnt_reg == 2'd3) begin
                        offset_next = after[31:0] + 32'd4;
                        fcnt_next   = 2'd0;
                        type_next   = '0;
                        if (end_sum > {2'b00, file_size_reg}) begin
                            rec0.record_kind  = KIND_OVERRUN;
                            rec0.chunk_length = len_shift;
                            rec0.data_start   = offset_next;
                            rec_cnt           = 2'd1;
                            phase_next        = PH_HALT;
                        end else begin
                            phase_next = PH_TYPE;
                        end
                    end else begin
                        fcnt_next = fcnt_reg + 2'd1;
                    end
                end
                PH_TYPE: begin
                    type_next = type_shift;
                    if (!letter) begin
                        // type bytes so far, left-aligned
                        rec0.record_kind  = KIND_BAD_TYPE;
                        rec0.chunk_length = len_reg;
                        rec0.data_start   = offset_reg;
                        rec_cnt           = 2'd1;
                        phase_next        = PH_HALT;
                        case (fcnt_reg)
                            2'd0:    rec0.chunk_type = {type_shift[7:0], 24'd0};
                            2'd1:    rec0.chunk_type = {type_shift[15:0], 16'd0};
                            2'd2:    rec0.chunk_type = {type_shift[23:0], 8'd0};
                            default: rec0.chunk_type = type_shift;
                        endcase
                    end else if (fcnt_reg == 2'd3) begin
                        fcnt_next   = 2'd0;
                        crc_next    = '0;
                        remain_next = len_reg;
                        phase_next  = (len_reg == '0) ? PH_CRC : PH_DATA;
                    end else begin
                        fcnt_next = fcnt_reg + 2'd1;
                    end
                end
                PH_DATA: begin
                    remain_next = remain_dec;
                    if (remain_dec == '0) begin
                        phase_next = PH_CRC;
                        fcnt_next  = 2'd0;
                        crc_next   = '0;
                    end
                end
                PH_CRC: begin
                    crc_next = {crc_reg[23:0], b};
                    if (fcnt_reg == 2'd3) begin
                        rec0.record_kind  = KIND_CHUNK;
                        rec0.chunk_type   = type_reg;
                        rec0.chunk_length = len_reg;
                        rec0.data_start   = offset_reg;
                        rec0.stored_crc   = crc_next;
                        rec_cnt           = 2'd1;
                        if (!first_seen_reg) begin
                            first_seen_next = 1'b1;
                            first_ihdr_next = (type_reg == TYPE_IHDR);
                            if (type_reg == TYPE_IHDR) begin
                                // header record uses this byte's header capture
                                rec1              = rec0;
                                rec1.record_kind  = KIND_HEADER;
                                rec1.image_width  = hdr_width_next;
                                rec1.image_height = hdr_height_next;
                                rec1.pixel_depth  = hdr_small_next[39:32];
                                rec1.color_mode   = hdr_small_next[31:24];
                                rec1.method_bytes = hdr_small_next[23:0];
                                rec_cnt           = 2'd2;
                            end
                        end
                        phase_next = PH_LEN;
                        fcnt_next  = 2'd0;
                        len_next   = '0;
                    end else begin
                        fcnt_next = fcnt_reg + 2'd1;
                    end
                end
                PH_HALT: begin
                    // ignore bytes until end of file
                end
                default: begin
                    phase_next = PH_HALT;
                end
            endcase

            pos_next = after[31:0];

            if (eof) begin
                // back to the signature phase with everything cleared
                phase_next      = PH_SIG;
                pos_next        = '0;
                fcnt_next       = 2'd0;
                sig_ok_next     = 1'b1;
                len_next        = '0;
                type_next       = '0;
                crc_next        = '0;
                remain_next     = '0;
                offset_next     = '0;
                first_seen_next = 1'b0;
                first_ihdr_next = 1'b0;
                hdr_width_next  = '0;
                hdr_height_next = '0;
                hdr_small_next  = '0;
            end

            if (rec_cnt == 2'd1) begin
                rec0.last_of_run = 1'b1;
            end else if (rec_cnt == 2'd2) begin
                rec1.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg  <= '0;
            phase_reg      <= PH_SIG;
            pos_reg        <= '0;
            fcnt_reg       <= 2'd0;
            sig_ok_reg     <= 1'b1;
            len_reg        <= '0;
            type_reg       <= '0;
            crc_reg        <= '0;
            remain_reg     <= '0;
            offset_reg     <= '0;
            first_seen_reg <= 1'b0;
            first_ihdr_reg <= 1'b0;
            hdr_width_reg  <= '0;
            hdr_height_reg <= '0;
            hdr_small_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                file_size_reg <= cfg_wr_data;
            end
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            fcnt_reg       <= fcnt_next;
            sig_ok_reg     <= sig_ok_next;
            len_reg        <= len_next;
            type_reg       <= type_next;
            crc_reg        <= crc_next;
            remain_reg     <= remain_next;
            offset_reg     <= offset_next;
            first_seen_reg <= first_seen_next;
            first_ihdr_reg <= first_ihdr_next;
            hdr_width_reg  <= hdr_width_next;
            hdr_height_reg <= hdr_height_next;
            hdr_small_reg  <= hdr_small_next;
        end
    end

    // result queue payload, no reset needed
    always_ff @(posedge aclk) begin
        if (rec_cnt != 2'd0) begin
            rq_mem[rq_wr_ptr_reg] <= rec0;
        end
        if (rec_cnt == 2'd2) begin
            rq_mem[rq_wr_ptr_reg + RQ_PTR_W'(1)] <= rec1;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rq_wr_ptr_reg <= '0;
            rq_rd_ptr_reg <= '0;
            rq_cnt_reg    <= '0;
        end else begin
            rq_wr_ptr_reg <= rq_wr_ptr_reg + RQ_PTR_W'(rec_cnt);
            if (m_xfer) begin
                rq_rd_ptr_reg <= rq_rd_ptr_reg + RQ_PTR_W'(1);
            end
            rq_cnt_reg <= rq_cnt_reg + RQ_CNT_W'(rec_cnt) - RQ_CNT_W'(m_xfer);
        end
    end

`ifndef SYNTHESIS
    // queue never overfills
    assert property (@(posedge aclk) disable iff (!aresetn)
        rq_cnt_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    // two records from one byte only at the end of the first chunk
    assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_cnt == 2'd2) |-> (phase_reg == PH_CRC && !first_seen_reg && fcnt_reg == 2'd3))
        else $error("double record outside first chunk end");

    // end of file puts the parser back at the signature start
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && eof) |=> (phase_reg == PH_SIG && pos_reg == '0 && sig_ok_reg))
        else $error("parser not cleared after end of file");

    // a halted parser produces nothing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HALT) |-> (rec_cnt == 2'd0))
        else $error("record produced while halted");
`endif

endmodule
